FILE: rtl/multilevel_feedback_queue_scheduler_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the multilevel feedback queue scheduler
// Clocked, reset-gated property wrappers.
// ---------------------------------------------------------------------------
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_MACROS_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define MFQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MFQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MFQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MFQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/mfqs_pkg.sv
// ---------------------------------------------------------------------------
// mfqs_pkg
// Shared constants and types of the feedback queue scheduler.
// ---------------------------------------------------------------------------
package mfqs_pkg;
  localparam int MaxJobs   = 16;
  localparam int NumLevels = 5;
  localparam int SlotW     = 4;
  localparam int TimeW     = 16;

  localparam logic [2:0] PH_NEW      = 3'd0;
  localparam logic [2:0] PH_READY    = 3'd1;
  localparam logic [2:0] PH_RUNNING  = 3'd2;
  localparam logic [2:0] PH_WAITING  = 3'd3;
  localparam logic [2:0] PH_FINISHED = 3'd4;

  localparam logic [2:0] OC_NONE     = 3'd0;
  localparam logic [2:0] OC_CONTINUE = 3'd1;
  localparam logic [2:0] OC_IO       = 3'd2;
  localparam logic [2:0] OC_FINISH   = 3'd3;
  localparam logic [2:0] OC_EXPIRE   = 3'd4;

  localparam logic [2:0] REG_JOB_COUNT = 3'd0;
  localparam logic [2:0] REG_AGING     = 3'd1;
  localparam logic [2:0] REG_SLICE0    = 3'd2;
  localparam logic [2:0] REG_SLICE4    = 3'd6;

  // one job slot record in the job memory
  typedef struct packed {
    logic [TimeW-1:0] arrival;
    logic [TimeW-1:0] remaining;
    logic [2:0]       phase;
    logic [2:0]       level;
    logic [4:0]       aging;
  } job_t;

  typedef struct packed {
    logic [4:0]  job_count;
    logic [4:0]  aging_limit;
    logic [39:0] slices;
  } cfg_t;
endpackage

FILE: rtl/multilevel_feedback_queue_scheduler.sv
// Sequence: a load word reads and then writes its job record and posts its result; a tick
//   word walks the configured job slots for arrivals, drains the queued I/O jobs, walks
//   the slots for aging, then dispatches, runs and posts its result.
// Throughput: one word at a time; the next word is accepted once the sequencer is idle,
//   and a result word not yet taken holds the sequencer before it posts the next one.
// Reset: synchronous rst_n marks all job records new through a clearing pass.
// ---------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// Job memory plus queue memory, walked by a sequencer each tick.
// ---------------------------------------------------------------------------
`include "multilevel_feedback_queue_scheduler_macros.svh"
module multilevel_feedback_queue_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: job_slot[3:0], arrival_tick[19:4], burst_length[35:20], wants_io[36],
  //        io_done_mask[52:37], zero fill to 56
  input  logic [55:0] in_tdata,
  // tuser: action
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: tick_now[15:0], ran_valid[16], ran_slot[20:17], outcome[23:21],
  //        level_after[26:24], finish_tick[42:27], all_done[43], zero fill to 48
  output logic [47:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int QDepth = mfqs_pkg::NumLevels * mfqs_pkg::MaxJobs;

  mfqs_pkg::cfg_t cfg;
  mfqs_cfg u_cfg (
    .clk, .rst_n, .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata),
    .pready(cfg_pready), .cfg
  );

  // memories: job records and queues (5 ready + io queue at level index 5)
  mfqs_pkg::job_t jmem [mfqs_pkg::MaxJobs];
  logic [3:0]     qmem [QDepth + mfqs_pkg::MaxJobs];

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LOAD_RD, S_LOAD_WR, S_ARR_RD, S_ARR_WR,
    S_IO_Q, S_IO_QW, S_IO_J, S_IO_WR, S_AGE_RD, S_AGE_WR,
    S_DSP, S_DSP_Q, S_RUN_RD, S_RUN_WR, S_OUT
  } state_t;
  state_t state_r;

  logic [3:0]  idx_r;
  logic [4:0]  n_r;
  logic [3:0]  head_r [6];
  logic [4:0]  cnt_r  [6];
  logic [55:0] din_r;
  logic        running_r;
  logic [3:0]  run_slot_r;
  logic [7:0]  slice_used_r;
  logic [15:0] clock_r;
  logic [4:0]  fin_cnt_r;
  logic [3:0]  jslot_r;
  mfqs_pkg::job_t jrd_r;
  logic [3:0]  qrd_r;
  logic        out_valid_r;
  logic [47:0] out_r;
  logic [47:0] out_hold_r;

  logic        jwe;
  logic [3:0]  jaddr;
  mfqs_pkg::job_t jwd;
  logic        qwe;
  logic [6:0]  qwaddr, qraddr;
  logic [3:0]  qwd;

  logic [4:0]  eff_cnt;
  assign eff_cnt = (cfg.job_count > 5'(mfqs_pkg::MaxJobs)) ? 5'(mfqs_pkg::MaxJobs)
                                                          : cfg.job_count;

  function automatic logic [6:0] qaddr(input logic [2:0] l, input logic [3:0] p);
    qaddr = {l, 4'd0} + {3'd0, p};
  endfunction

  // memory ports
  always_ff @(posedge clk) begin
    if (jwe) begin
      jmem[jaddr] <= jwd;
    end
    jrd_r <= jmem[jaddr];
    if (qwe) begin
      qmem[qwaddr] <= qwd;
    end
    qrd_r <= qmem[qraddr];
  end

  // combinational step logic
  logic [2:0]  plvl;
  logic        ph_found;
  logic [2:0]  rlvl;
  logic [7:0]  slice_sel;
  logic [15:0] rem_dec;
  logic [7:0]  su_inc;
  logic [4:0]  ag;
  logic        ldok;

  always_comb begin
    ph_found = 1'b0;
    plvl = 3'd0;
    for (int l = mfqs_pkg::NumLevels - 1; l >= 0; l--) begin
      if (cnt_r[l] != 5'd0) begin
        ph_found = 1'b1;
        plvl = 3'(l);
      end
    end
    rlvl = (jrd_r.level > 3'd4) ? 3'd4 : jrd_r.level;
    slice_sel = cfg.slices[8*rlvl +: 8];
    rem_dec = (jrd_r.remaining != 16'd0) ? jrd_r.remaining - 16'd1 : 16'd0;
    su_inc = (slice_used_r != 8'd255) ? slice_used_r + 8'd1 : slice_used_r;
    ag = (jrd_r.aging < cfg.aging_limit) ? jrd_r.aging + 5'd1 : jrd_r.aging;
    ldok = (jrd_r.phase == mfqs_pkg::PH_NEW) || (jrd_r.phase == mfqs_pkg::PH_FINISHED);

    jwe = 1'b0;
    jaddr = idx_r;
    jwd = jrd_r;
    qwe = 1'b0;
    qwaddr = 7'd0;
    qwd = idx_r;
    qraddr = qaddr(3'd5, head_r[5]);
    unique case (state_r)
      S_CLEAR: begin
        jwe = 1'b1;
        jwd = '0;
      end
      S_LOAD_RD: jaddr = din_r[3:0];
      S_LOAD_WR: begin
        jaddr = din_r[3:0];
        jwe = ldok;
        jwd.arrival = din_r[19:4];
        jwd.remaining = din_r[35:20];
        jwd.phase = mfqs_pkg::PH_NEW;
        jwd.level = 3'd0;
        jwd.aging = 5'd0;
      end
      S_ARR_WR: begin
        if (jrd_r.phase == mfqs_pkg::PH_NEW && jrd_r.arrival == clock_r) begin
          jwe = 1'b1;
          jwd.phase = mfqs_pkg::PH_READY;
          qwe = (cnt_r[0] < 5'd16);
          qwaddr = qaddr(3'd0, head_r[0] + cnt_r[0][3:0]);
        end
      end
      S_IO_J: jaddr = qrd_r;
      S_IO_WR: begin
        jaddr = jslot_r;
        if (din_r[37 + 32'(idx_r)]) begin
          jwe = 1'b1;
          jwd.phase = mfqs_pkg::PH_READY;
          qwe = (cnt_r[rlvl] < 5'd16);
          qwaddr = qaddr(rlvl, head_r[rlvl] + cnt_r[rlvl][3:0]);
          qwd = jslot_r;
        end else begin
          qwe = 1'b1;
          qwaddr = qaddr(3'd5, head_r[5] + cnt_r[5][3:0]);
          qwd = jslot_r;
        end
      end
      S_AGE_WR: begin
        if (jrd_r.phase == mfqs_pkg::PH_READY) begin
          jwe = 1'b1;
          jwd.aging = ag;
          if (ag >= cfg.aging_limit && jrd_r.level != 3'd0) begin
            jwd.level = jrd_r.level - 3'd1;
            jwd.aging = 5'd0;
          end
        end
      end
      S_DSP: qraddr = qaddr(plvl, head_r[plvl]);
      S_RUN_RD: jaddr = run_slot_r;
      S_RUN_WR: begin
        jaddr = run_slot_r;
        if (running_r) begin
          jwe = 1'b1;
          jwd.remaining = rem_dec;
          jwd.phase = mfqs_pkg::PH_RUNNING;
          if (din_r[36]) begin
            jwd.phase = mfqs_pkg::PH_WAITING;
            qwe = (cnt_r[5] < 5'd16);
            qwaddr = qaddr(3'd5, head_r[5] + cnt_r[5][3:0]);
            qwd = run_slot_r;
          end else if (rem_dec == 16'd0) begin
            jwd.phase = mfqs_pkg::PH_FINISHED;
          end else if (su_inc >= slice_sel) begin
            jwd.phase = mfqs_pkg::PH_READY;
            if (jrd_r.level < 3'd4) begin
              jwd.level = jrd_r.level + 3'd1;
            end
            qwe = (cnt_r[jwd.level] < 5'd16);
            qwaddr = qaddr(jwd.level, head_r[jwd.level] + cnt_r[jwd.level][3:0]);
            qwd = run_slot_r;
          end
        end
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_hold_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      idx_r <= 4'd0;
      n_r <= 5'd0;
      for (int l = 0; l < 6; l++) begin
        head_r[l] <= 4'd0;
        cnt_r[l] <= 5'd0;
      end
      running_r <= 1'b0;
      run_slot_r <= 4'd0;
      slice_used_r <= 8'd0;
      clock_r <= 16'd0;
      fin_cnt_r <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          idx_r <= idx_r + 4'd1;
          if (idx_r == 4'd15) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            din_r <= in_tdata;
            idx_r <= 4'd0;
            n_r <= cnt_r[5];
            out_r <= '0;
            state_r <= in_tuser ? ((eff_cnt == 5'd0) ? S_IO_Q : S_ARR_RD) : S_LOAD_RD;
          end
        end
        S_LOAD_RD: state_r <= S_LOAD_WR;
        S_LOAD_WR: begin
          if (ldok && jrd_r.phase == mfqs_pkg::PH_FINISHED && fin_cnt_r != 5'd0) begin
            fin_cnt_r <= fin_cnt_r - 5'd1;
          end
          out_r[15:0] <= clock_r;
          state_r <= S_OUT;
        end
        S_ARR_RD: state_r <= S_ARR_WR;
        S_ARR_WR: begin
          if (qwe) begin
            cnt_r[0] <= cnt_r[0] + 5'd1;
          end
          if ({1'b0, idx_r} + 5'd1 >= eff_cnt) begin
            idx_r <= 4'd0;
            n_r <= cnt_r[5];
            state_r <= S_IO_Q;
          end else begin
            idx_r <= idx_r + 4'd1;
            state_r <= S_ARR_RD;
          end
        end
        S_IO_Q: begin
          if (idx_r == 4'd0 && n_r == 5'd0) begin
            idx_r <= 4'd0;
            state_r <= (eff_cnt == 5'd0) ? S_DSP : S_AGE_RD;
          end else begin
            state_r <= S_IO_QW;
          end
        end
        S_IO_QW: state_r <= S_IO_J;
        S_IO_J: begin
          jslot_r <= qrd_r;
          head_r[5] <= head_r[5] + 4'd1;
          cnt_r[5] <= cnt_r[5] - 5'd1;
          state_r <= S_IO_WR;
        end
        S_IO_WR: begin
          if (qwe) begin
            if (din_r[37 + 32'(idx_r)]) begin
              cnt_r[rlvl] <= cnt_r[rlvl] + 5'd1;
            end else begin
              cnt_r[5] <= cnt_r[5] + 5'd1;
            end
          end
          n_r <= n_r - 5'd1;
          if (n_r == 5'd1) begin
            idx_r <= 4'd0;
            state_r <= (eff_cnt == 5'd0) ? S_DSP : S_AGE_RD;
          end else begin
            idx_r <= idx_r + 4'd1;
            state_r <= S_IO_QW;
          end
        end
        S_AGE_RD: state_r <= S_AGE_WR;
        S_AGE_WR: begin
          idx_r <= idx_r + 4'd1;
          state_r <= ({1'b0, idx_r} + 5'd1 >= eff_cnt) ? S_DSP : S_AGE_RD;
        end
        S_DSP: begin
          if (!running_r && ph_found) begin
            head_r[plvl] <= head_r[plvl] + 4'd1;
            cnt_r[plvl] <= cnt_r[plvl] - 5'd1;
            slice_used_r <= 8'd0;
            running_r <= 1'b1;
            state_r <= S_DSP_Q;
          end else begin
            state_r <= running_r ? S_RUN_RD : S_RUN_WR;
          end
        end
        S_DSP_Q: begin
          run_slot_r <= qrd_r;
          state_r <= S_RUN_RD;
        end
        S_RUN_RD: state_r <= S_RUN_WR;
        S_RUN_WR: begin
          out_r[15:0] <= clock_r;
          clock_r <= clock_r + 16'd1;
          if (running_r) begin
            out_r[16] <= 1'b1;
            out_r[20:17] <= run_slot_r;
            out_r[26:24] <= jwd.level;
            slice_used_r <= din_r[36] ? 8'd0 : su_inc;
            if (qwe) begin
              cnt_r[din_r[36] ? 3'd5 : jwd.level] <=
                cnt_r[din_r[36] ? 3'd5 : jwd.level] + 5'd1;
            end
            if (din_r[36]) begin
              out_r[23:21] <= mfqs_pkg::OC_IO;
              running_r <= 1'b0;
            end else if (rem_dec == 16'd0) begin
              out_r[23:21] <= mfqs_pkg::OC_FINISH;
              out_r[42:27] <= clock_r + 16'd1;
              if (fin_cnt_r != 5'd31) begin
                fin_cnt_r <= fin_cnt_r + 5'd1;
              end
              running_r <= 1'b0;
            end else if (su_inc >= slice_sel) begin
              out_r[23:21] <= mfqs_pkg::OC_EXPIRE;
              running_r <= 1'b0;
            end else begin
              out_r[23:21] <= mfqs_pkg::OC_CONTINUE;
            end
          end
          state_r <= S_OUT;
        end
        // post the result word once the output register is free
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_hold_r <= {4'd0, (fin_cnt_r == eff_cnt), out_r[42:0]};
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `MFQ_ASSERT_IMP(a_ready_idle, clk, rst_n, in_tready, state_r == S_IDLE)
  `MFQ_ASSERT_NXT(a_out_after, clk, rst_n, state_r == S_OUT, out_valid_r)
  `MFQ_ASSERT_IMP(a_io_bound, clk, rst_n, 1'b1, cnt_r[5] <= 5'd16)
endmodule

FILE: rtl/mfqs_cfg.sv
// ---------------------------------------------------------------------------
// mfqs_cfg
// APB register file for job count, aging limit and slice lengths.
// ---------------------------------------------------------------------------
module mfqs_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output mfqs_pkg::cfg_t     cfg
);
  mfqs_pkg::cfg_t cfg_r;
  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // write registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.job_count   <= 5'd0;
      cfg_r.aging_limit <= 5'd20;
      cfg_r.slices      <= {8'd16, 8'd8, 8'd4, 8'd2, 8'd1};
    end else if (wr) begin
      if (idx == mfqs_pkg::REG_JOB_COUNT) begin
        cfg_r.job_count <= pwdata[4:0];
      end else if (idx == mfqs_pkg::REG_AGING) begin
        cfg_r.aging_limit <= pwdata[4:0];
      end else if (idx >= mfqs_pkg::REG_SLICE0 && idx <= mfqs_pkg::REG_SLICE4) begin
        cfg_r.slices[8*(idx-mfqs_pkg::REG_SLICE0) +: 8] <= pwdata[7:0];
      end
    end
  end

  // read mux
  always_comb begin
    prdata = 32'd0;
    if (idx == mfqs_pkg::REG_JOB_COUNT) begin
      prdata = {27'd0, cfg_r.job_count};
    end else if (idx == mfqs_pkg::REG_AGING) begin
      prdata = {27'd0, cfg_r.aging_limit};
    end else if (idx >= mfqs_pkg::REG_SLICE0 && idx <= mfqs_pkg::REG_SLICE4) begin
      prdata = {24'd0, cfg_r.slices[8*(idx-mfqs_pkg::REG_SLICE0) +: 8]};
    end
  end
endmodule
